FILE: sv/date_add_subtract_days_unit_assert.svh
// Assertion macros for the date add/subtract days unit.
// Expects clk and rst in the scope of the file that includes it.
`ifndef DATE_ADD_SUBTRACT_DAYS_UNIT_ASSERT_SVH
`define DATE_ADD_SUBTRACT_DAYS_UNIT_ASSERT_SVH

// Antecedent in this cycle, consequent in the next.
`define DASD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent and consequent in the same cycle.
`define DASD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/dasd_pkg.sv
// Shared types, constants and calendar helpers for the date add/subtract days unit.
// Used by dasd_datapath and date_add_subtract_days_unit; depends on nothing.
package dasd_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int ST_W   = 2;
  localparam int CNT_FIELD_W = 16;

  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
  localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd0;
  localparam logic [MON_W-1:0]  MON_JAN  = 4'd1;
  localparam logic [MON_W-1:0]  MON_FEB  = 4'd2;
  localparam logic [MON_W-1:0]  MON_APR  = 4'd4;
  localparam logic [MON_W-1:0]  MON_JUN  = 4'd6;
  localparam logic [MON_W-1:0]  MON_SEP  = 4'd9;
  localparam logic [MON_W-1:0]  MON_NOV  = 4'd11;
  localparam logic [MON_W-1:0]  MON_DEC  = 4'd12;
  localparam logic [DAY_W-1:0]  DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]  LEN_LONG  = 5'd31;
  localparam logic [DAY_W-1:0]  LEN_SHORT = 5'd30;
  localparam logic [DAY_W-1:0]  LEN_LEAP  = 5'd29;
  localparam logic [DAY_W-1:0]  LEN_FEB   = 5'd28;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SUB = 1'b1;

  // Microprogram step addresses.
  localparam int PC_W = 2;
  localparam logic [PC_W-1:0] PC_FETCH = 2'd0;
  localparam logic [PC_W-1:0] PC_CHECK = 2'd1;
  localparam logic [PC_W-1:0] PC_WALK  = 2'd2;
  localparam logic [PC_W-1:0] PC_EMIT  = 2'd3;

  // Jump conditions.
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] COND_ALWAYS  = 3'd0;
  localparam logic [COND_W-1:0] COND_IN      = 3'd1;
  localparam logic [COND_W-1:0] COND_BAD     = 3'd2;
  localparam logic [COND_W-1:0] COND_END     = 3'd3;
  localparam logic [COND_W-1:0] COND_OUTFREE = 3'd4;

  typedef struct packed {
    logic              take;
    logic              check;
    logic              walk;
    logic              emit;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   jt;
    logic [PC_W-1:0]   jf;
  } ucode_t;

  typedef struct packed {
    logic load;
    logic check;
    logic walk;
  } dp_ctrl_t;

  typedef struct packed {
    logic bad;
    logic done;
  } dp_flags_t;

  function automatic logic [DAY_W-1:0] days_in(input logic [MON_W-1:0] m,
                                               input logic [YEAR_W-1:0] y);
    logic [DAY_W-1:0] len;
    case (m) inside
      MON_FEB:                         len = (y[1:0] == 2'b00) ? LEN_LEAP : LEN_FEB;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_SHORT;
      default:                         len = LEN_LONG;
    endcase
    return len;
  endfunction

  // Control store: one word per step.
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_FETCH: w = '{take: 1'b1, check: 1'b0, walk: 1'b0, emit: 1'b0,
                      cond: COND_IN, jt: PC_CHECK, jf: PC_FETCH};
      PC_CHECK: w = '{take: 1'b0, check: 1'b1, walk: 1'b0, emit: 1'b0,
                      cond: COND_BAD, jt: PC_EMIT, jf: PC_WALK};
      PC_WALK:  w = '{take: 1'b0, check: 1'b0, walk: 1'b1, emit: 1'b0,
                      cond: COND_END, jt: PC_EMIT, jf: PC_WALK};
      PC_EMIT:  w = '{take: 1'b0, check: 1'b0, walk: 1'b0, emit: 1'b1,
                      cond: COND_OUTFREE, jt: PC_FETCH, jf: PC_EMIT};
      default:  w = '{take: 1'b0, check: 1'b0, walk: 1'b0, emit: 1'b0,
                      cond: COND_ALWAYS, jt: PC_FETCH, jf: PC_FETCH};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/dasd_datapath.sv
// Date registers, day counter and one-day step logic for the date unit.
// Driven by the microsequencer in date_add_subtract_days_unit; uses dasd_pkg.
module dasd_datapath #(
  parameter int CntW = 16
) (
  input  logic                             clk,
  input  dasd_pkg::dp_ctrl_t               ctrl,
  input  logic                             command,
  input  logic [dasd_pkg::DAY_W-1:0]       start_day,
  input  logic [dasd_pkg::MON_W-1:0]       start_month,
  input  logic [dasd_pkg::YEAR_W-1:0]      start_year,
  input  logic [dasd_pkg::CNT_FIELD_W-1:0] day_count,
  output dasd_pkg::dp_flags_t              flags,
  output logic [dasd_pkg::DAY_W-1:0]       res_day,
  output logic [dasd_pkg::MON_W-1:0]       res_month,
  output logic [dasd_pkg::YEAR_W-1:0]      res_year,
  output logic [dasd_pkg::ST_W-1:0]        res_status
);

  logic                        cmd;
  logic [dasd_pkg::DAY_W-1:0]  d0, d, d_next;
  logic [dasd_pkg::MON_W-1:0]  m0, m, m_next;
  logic [dasd_pkg::YEAR_W-1:0] y0, y, y_next;
  logic [CntW-1:0]             cnt;
  logic [dasd_pkg::ST_W-1:0]   st;
  logic                        range_hit;
  logic                        cnt_zero;
  logic [dasd_pkg::DAY_W-1:0]  len_cur;
  logic [dasd_pkg::DAY_W-1:0]  len_prev;

  assign len_cur  = dasd_pkg::days_in(m, y);
  assign len_prev = dasd_pkg::days_in(m - dasd_pkg::MON_W'(1), y);
  assign cnt_zero = (cnt == '0);

  // Next date one day forward or back, and the year-range edge.
  always_comb begin
    d_next    = d;
    m_next    = m;
    y_next    = y;
    range_hit = 1'b0;
    if (cmd == dasd_pkg::CMD_ADD) begin
      if (d == len_cur) begin
        d_next = dasd_pkg::DAY_FIRST;
        if (m == dasd_pkg::MON_DEC) begin
          range_hit = (y == dasd_pkg::YEAR_MAX);
          m_next    = dasd_pkg::MON_JAN;
          y_next    = y + dasd_pkg::YEAR_W'(1);
        end else begin
          m_next = m + dasd_pkg::MON_W'(1);
        end
      end else begin
        d_next = d + dasd_pkg::DAY_W'(1);
      end
    end else begin
      if (d == dasd_pkg::DAY_FIRST) begin
        if (m == dasd_pkg::MON_JAN) begin
          range_hit = (y == dasd_pkg::YEAR_MIN);
          m_next    = dasd_pkg::MON_DEC;
          y_next    = y - dasd_pkg::YEAR_W'(1);
          d_next    = dasd_pkg::LEN_LONG;
        end else begin
          m_next = m - dasd_pkg::MON_W'(1);
          d_next = len_prev;
        end
      end else begin
        d_next = d - dasd_pkg::DAY_W'(1);
      end
    end
  end

  assign flags.bad  = (m == '0) || (m > dasd_pkg::MON_DEC) || (y > dasd_pkg::YEAR_MAX)
                   || (d == '0) || (d > len_cur);
  assign flags.done = cnt_zero || range_hit;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd <= command;
      d0  <= start_day;
      m0  <= start_month;
      y0  <= start_year;
      d   <= start_day;
      m   <= start_month;
      y   <= start_year;
      cnt <= day_count[CntW-1:0];
      st  <= dasd_pkg::ST_OK;
    end else if (ctrl.check) begin
      if (flags.bad) begin
        st <= dasd_pkg::ST_INVALID;
      end
    end else if (ctrl.walk && !cnt_zero) begin
      if (range_hit) begin
        st <= dasd_pkg::ST_RANGE;
      end else begin
        d   <= d_next;
        m   <= m_next;
        y   <= y_next;
        cnt <= cnt - CntW'(1);
      end
    end
  end

  // On any error, hand back the start date.
  assign res_status = st;
  assign res_day    = (st == dasd_pkg::ST_OK) ? d : d0;
  assign res_month  = (st == dasd_pkg::ST_OK) ? m : m0;
  assign res_year   = (st == dasd_pkg::ST_OK) ? y : y0;

endmodule

FILE: sv/date_add_subtract_days_unit.sv
// Top level of the date add/subtract days unit: microsequencer and result register.
// Uses dasd_pkg, dasd_datapath and date_add_subtract_days_unit_assert.svh.

// Moves a calendar date forward (command 0) or back (command 1) by day_count days,
// one day per clock, with February at 29 days in every year divisible by 4.
// Only the low COUNT_WIDTH bits of day_count are used (all 16 when COUNT_WIDTH >= 16).
// An item goes from its transfer to the next input transfer through one fetch step,
// one validity check, the day-walk step, repeated until the masked day count runs
// out, and one step to load the result register; the load step also waits while an
// earlier result is still held. A bad start date skips the walk: the check step goes
// straight to the load step. A year carried outside 0..9999 stops the walk and
// returns status 2. Both echo the start date.
// The result register lets the next item be taken while a result waits.
module date_add_subtract_days_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             command,
  input  logic [dasd_pkg::DAY_W-1:0]       start_day,
  input  logic [dasd_pkg::MON_W-1:0]       start_month,
  input  logic [dasd_pkg::YEAR_W-1:0]      start_year,
  input  logic [dasd_pkg::CNT_FIELD_W-1:0] day_count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dasd_pkg::DAY_W-1:0]       end_day,
  output logic [dasd_pkg::MON_W-1:0]       end_month,
  output logic [dasd_pkg::YEAR_W-1:0]      end_year,
  output logic [dasd_pkg::ST_W-1:0]        status
);

  localparam int CntW = (COUNT_WIDTH < dasd_pkg::CNT_FIELD_W) ? COUNT_WIDTH
                                                               : dasd_pkg::CNT_FIELD_W;

  logic [dasd_pkg::PC_W-1:0]   pc, pc_next;
  dasd_pkg::ucode_t            word;
  dasd_pkg::dp_ctrl_t          ctrl;
  dasd_pkg::dp_flags_t         flags;
  logic                        cond_true;
  logic                        out_free;
  logic                        out_load;
  logic [dasd_pkg::DAY_W-1:0]  res_day;
  logic [dasd_pkg::MON_W-1:0]  res_month;
  logic [dasd_pkg::YEAR_W-1:0] res_year;
  logic [dasd_pkg::ST_W-1:0]   res_status;

  assign word     = dasd_pkg::ucode(pc);
  assign out_free = !out_valid || out_ready;
  assign in_ready = word.take;
  assign out_load = word.emit && out_free;

  assign ctrl.load  = in_valid && word.take;
  assign ctrl.check = word.check;
  assign ctrl.walk  = word.walk;

  always_comb begin
    unique case (word.cond)
      dasd_pkg::COND_ALWAYS:  cond_true = 1'b1;
      dasd_pkg::COND_IN:      cond_true = in_valid;
      dasd_pkg::COND_BAD:     cond_true = flags.bad;
      dasd_pkg::COND_END:     cond_true = flags.done;
      dasd_pkg::COND_OUTFREE: cond_true = out_free;
      default:                cond_true = 1'b1;
    endcase
    pc_next = cond_true ? word.jt : word.jf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= dasd_pkg::PC_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  dasd_datapath #(
    .CntW (CntW)
  ) u_datapath (
    .clk         (clk),
    .ctrl        (ctrl),
    .command     (command),
    .start_day   (start_day),
    .start_month (start_month),
    .start_year  (start_year),
    .day_count   (day_count),
    .flags       (flags),
    .res_day     (res_day),
    .res_month   (res_month),
    .res_year    (res_year),
    .res_status  (res_status)
  );

  // Result register: hold until the output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      end_day   <= res_day;
      end_month <= res_month;
      end_year  <= res_year;
      status    <= res_status;
    end
  end

`include "date_add_subtract_days_unit_assert.svh"

  `DASD_ASSERT_NEXT(a_take_to_check, in_valid && in_ready, pc == dasd_pkg::PC_CHECK, "input transfer did not start the check step")
  `DASD_ASSERT_NEXT(a_walk_holds, pc == dasd_pkg::PC_WALK && !flags.done, pc == dasd_pkg::PC_WALK, "walk left before the count ran out")
  `DASD_ASSERT_NEXT(a_emit_loads, pc == dasd_pkg::PC_EMIT && out_free, out_valid && pc == dasd_pkg::PC_FETCH, "emit step did not load the result")
  `DASD_ASSERT_NOW(a_ready_only_fetch, in_ready, pc == dasd_pkg::PC_FETCH, "input ready outside the fetch step")

endmodule
